FILE: hdl/fomd_pkg.sv
// Shared types and constants of the field-oriented mecanum drive block.
// Depends on nothing; every other file of the block depends on it.
package fomd_pkg;

	// Field and register widths
	localparam int RATE_W     = 11;
	localparam int ELAPSED_W  = 8;
	localparam int STICK_W    = 8;
	localparam int HEADING_W  = 19;
	localparam int POWER_W    = 8;
	localparam int SDZ_W      = 7;
	localparam int RDZ_W      = 8;
	localparam int SCALE_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int DEG_W      = 9;
	localparam int NUM_WHEELS = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_DZ     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE = 2'd2;

	// Register reset values
	localparam logic [SDZ_W-1:0]   SDZ_RST   = 7'd15;
	localparam logic [RDZ_W-1:0]   RDZ_RST   = 8'd3;
	localparam logic [SCALE_W-1:0] SCALE_RST = 9'd192;

	localparam int FULL_TURN_MDEG = 360000;
	localparam int POWER_LIMIT    = 100;
	localparam int SCALE_SHIFT    = 8;
	// floor(h / 1000) == (h * RECIP_1000) >> RECIP_SHIFT for h up to 360000
	localparam int RECIP_1000     = 536871;
	localparam int RECIP_SHIFT    = 29;
	localparam int DEG_FULL       = 360;

	// sin of 0..90 whole degrees, Q1.14
	localparam logic [14:0] SINE_Q14 [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11983, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// Multiplier operations; the tag is registered alongside the product
	typedef enum logic [3:0] {
		OP_NONE,
		OP_RATE,
		OP_RECIP,
		OP_CX,
		OP_SY,
		OP_SX,
		OP_CY,
		OP_W0,
		OP_W1,
		OP_W2,
		OP_W3
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic joystick;
	} sts_t;

endpackage

FILE: hdl/fomd_if.sv
// Request channels of the mecanum drive block: sample in, result out.
// Depends on fomd_pkg for field widths.
interface fomd_sample_if;
	logic valid;
	logic ready;
	logic mode;
	logic signed [fomd_pkg::RATE_W-1:0] gyro_rate;
	logic [fomd_pkg::ELAPSED_W-1:0] elapsed_ms;
	logic signed [fomd_pkg::STICK_W-1:0] stick_x;
	logic signed [fomd_pkg::STICK_W-1:0] stick_y;
	logic signed [fomd_pkg::STICK_W-1:0] stick_turn;

	modport source (output valid, mode, gyro_rate, elapsed_ms, stick_x, stick_y, stick_turn,
		input ready);
	modport sink (input valid, mode, gyro_rate, elapsed_ms, stick_x, stick_y, stick_turn,
		output ready);
endinterface

interface fomd_result_if;
	logic valid;
	logic ready;
	logic [fomd_pkg::HEADING_W-1:0] heading_mdeg;
	logic signed [fomd_pkg::POWER_W-1:0] front_left_power;
	logic signed [fomd_pkg::POWER_W-1:0] back_left_power;
	logic signed [fomd_pkg::POWER_W-1:0] front_right_power;
	logic signed [fomd_pkg::POWER_W-1:0] back_right_power;

	modport source (output valid, heading_mdeg, front_left_power, back_left_power,
		front_right_power, back_right_power, input ready);
	modport sink (input valid, heading_mdeg, front_left_power, back_left_power,
		front_right_power, back_right_power, output ready);
endinterface

FILE: hdl/fomd_dp.sv
// Datapath of the mecanum drive: registers, trig lookup, one shared multiplier
// and the result register. Depends on fomd_pkg; driven by fomd_ctrl commands.
module fomd_dp #(
	parameter int TRIG_FRACTION_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fomd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fomd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  fomd_pkg::cmd_t cmd,
	output fomd_pkg::sts_t sts,
	input  logic mode,
	input  logic signed [fomd_pkg::RATE_W-1:0] gyro_rate,
	input  logic [fomd_pkg::ELAPSED_W-1:0] elapsed_ms,
	input  logic signed [fomd_pkg::STICK_W-1:0] stick_x,
	input  logic signed [fomd_pkg::STICK_W-1:0] stick_y,
	input  logic signed [fomd_pkg::STICK_W-1:0] stick_turn,
	output logic [fomd_pkg::HEADING_W-1:0] heading_mdeg,
	output logic signed [fomd_pkg::POWER_W-1:0] front_left_power,
	output logic signed [fomd_pkg::POWER_W-1:0] back_left_power,
	output logic signed [fomd_pkg::POWER_W-1:0] front_right_power,
	output logic signed [fomd_pkg::POWER_W-1:0] back_right_power
);
	import fomd_pkg::*;

	localparam int F         = TRIG_FRACTION_BITS;
	localparam int TW        = F + 2;
	localparam int MW        = (TW > 21) ? TW : 21;
	localparam int PW        = 2 * MW;
	localparam int SW        = PW + 1;
	localparam int RX_W      = 10;
	localparam int MIX_W     = 11;
	localparam int HS_W      = HEADING_W + 2;
	localparam int PWR_W     = 24;
	localparam int SH_DN     = (F < 14) ? 14 - F : 0;
	localparam int SH_UP     = (F > 14) ? F - 14 : 0;
	localparam int RND       = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;
	localparam int TRUNC_ADJ = (1 << F) - 1;

	localparam logic signed [HS_W-1:0]  FULL_TURN  = HS_W'(FULL_TURN_MDEG);
	localparam logic signed [PWR_W-1:0] PLIM_POS   = PWR_W'(POWER_LIMIT);
	localparam logic signed [PWR_W-1:0] PLIM_NEG   = -PWR_W'(POWER_LIMIT);
	localparam logic signed [PWR_W-1:0] SCALE_ADJ  = PWR_W'((1 << SCALE_SHIFT) - 1);

	// configuration
	logic [SDZ_W-1:0]   sdz_q;
	logic [RDZ_W-1:0]   rdz_q;
	logic [SCALE_W-1:0] scale_q;

	// block state
	logic [HEADING_W-1:0] heading_q;
	logic [ELAPSED_W-1:0] prior_q;
	logic [DEG_W-1:0]     deg_q;
	logic signed [POWER_W-1:0] powers_q [NUM_WHEELS];

	// captured sample and work registers
	logic joy_q;
	logic signed [RATE_W-1:0]  rate_q;
	logic [ELAPSED_W-1:0]      elapsed_q;
	logic signed [STICK_W-1:0] x_q, y_q, t_q;
	logic signed [TW-1:0]      s_q, c_q;
	logic signed [PW-1:0]      acc_q;
	logic signed [RX_W-1:0]    rx_q, ry_q;
	logic signed [PW-1:0]      prod_s1;
	op_t                       tag_s1;

	// result register
	logic [HEADING_W-1:0]      res_heading_q;
	logic signed [POWER_W-1:0] res_power_q [NUM_WHEELS];

	logic [STICK_W:0]         ax, ay;
	logic [DEG_W-1:0]         cos_deg;
	logic signed [TW-1:0]     sin_now, cos_now;
	logic signed [MIX_W-1:0]  mix [NUM_WHEELS];
	logic signed [MIX_W-1:0]  rx_w, ry_w, t_w;
	logic signed [MW-1:0]     a_op, b_op;
	logic signed [PW-1:0]     prod;
	logic [RATE_W-1:0]        rate_mag;
	logic signed [HS_W-1:0]   hsum;
	logic [HEADING_W-1:0]     hwrap;
	logic [DEG_W-1:0]         deg_raw, deg_next;
	logic signed [SW-1:0]     rx_sum, ry_sum;
	logic signed [PWR_W-1:0]  pw_full, pw_adj, pw_div;
	logic signed [POWER_W-1:0] pwr_sat;

	// signed value of sin(deg) with F fraction bits, deg in 0..359
	function automatic logic signed [TW-1:0] trig_value(input logic [DEG_W-1:0] deg);
		logic [DEG_W-1:0] fold;
		logic neg;
		logic [31:0] mag;
		if (deg <= 9'd90) begin
			fold = deg;
			neg = 1'b0;
		end else if (deg <= 9'd180) begin
			fold = 9'd180 - deg;
			neg = 1'b0;
		end else if (deg <= 9'd270) begin
			fold = deg - 9'd180;
			neg = 1'b1;
		end else begin
			fold = 9'd360 - deg;
			neg = 1'b1;
		end
		mag = ((32'(SINE_Q14[fold[6:0]]) + 32'(RND)) >> SH_DN) << SH_UP;
		trig_value = neg ? -TW'(mag) : TW'(mag);
	endfunction

	// divide by 2^F truncating toward zero
	function automatic logic signed [RX_W-1:0] trunc_shift(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] adj;
		adj = v + (v[SW-1] ? SW'(TRUNC_ADJ) : SW'(0));
		trunc_shift = RX_W'(adj >>> F);
	endfunction

	always_comb begin
		ax = stick_x[STICK_W-1] ? ((STICK_W+1)'(0) - (STICK_W+1)'(stick_x))
			: (STICK_W+1)'(stick_x);
		ay = stick_y[STICK_W-1] ? ((STICK_W+1)'(0) - (STICK_W+1)'(stick_y))
			: (STICK_W+1)'(stick_y);
		cos_deg = (deg_q >= 9'd270) ? deg_q - 9'd270 : deg_q + 9'd90;
		sin_now = trig_value(deg_q);
		cos_now = trig_value(cos_deg);

		rx_w = MIX_W'(rx_q);
		ry_w = MIX_W'(ry_q);
		t_w  = MIX_W'(t_q);
		mix[0] = ry_w + rx_w - t_w;
		mix[1] = ry_w - rx_w - t_w;
		mix[2] = rx_w - ry_w - t_w;
		mix[3] = -ry_w - rx_w - t_w;
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_RATE: begin
				a_op = MW'(rate_q);
				b_op = MW'(prior_q);
			end
			OP_RECIP: begin
				a_op = MW'(heading_q);
				b_op = MW'(RECIP_1000);
			end
			OP_CX: begin
				a_op = MW'(c_q);
				b_op = MW'(x_q);
			end
			OP_SY: begin
				a_op = MW'(s_q);
				b_op = MW'(y_q);
			end
			OP_SX: begin
				a_op = MW'(s_q);
				b_op = MW'(x_q);
			end
			OP_CY: begin
				a_op = MW'(c_q);
				b_op = MW'(y_q);
			end
			OP_W0: begin
				a_op = MW'(mix[0]);
				b_op = MW'(scale_q);
			end
			OP_W1: begin
				a_op = MW'(mix[1]);
				b_op = MW'(scale_q);
			end
			OP_W2: begin
				a_op = MW'(mix[2]);
				b_op = MW'(scale_q);
			end
			OP_W3: begin
				a_op = MW'(mix[3]);
				b_op = MW'(scale_q);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
		prod = a_op * b_op;
	end

	// consumers of the registered product
	always_comb begin
		rate_mag = rate_q[RATE_W-1] ? RATE_W'(-rate_q) : RATE_W'(rate_q);
		hsum = HS_W'({2'b00, heading_q}) + HS_W'(prod_s1);
		if (hsum > FULL_TURN)
			hwrap = HEADING_W'(hsum - FULL_TURN);
		else if (hsum[HS_W-1])
			hwrap = HEADING_W'(hsum + FULL_TURN);
		else
			hwrap = HEADING_W'(hsum);

		deg_raw = prod_s1[RECIP_SHIFT +: DEG_W];
		deg_next = (deg_raw == DEG_W'(DEG_FULL)) ? '0 : deg_raw;

		rx_sum = SW'(acc_q) - SW'(prod_s1);
		ry_sum = SW'(acc_q) + SW'(prod_s1);

		pw_full = PWR_W'(prod_s1);
		pw_adj = pw_full + (pw_full[PWR_W-1] ? SCALE_ADJ : PWR_W'(0));
		pw_div = pw_adj >>> SCALE_SHIFT;
		if (pw_div > PLIM_POS)
			pwr_sat = POWER_W'(PLIM_POS);
		else if (pw_div < PLIM_NEG)
			pwr_sat = POWER_W'(PLIM_NEG);
		else
			pwr_sat = POWER_W'(pw_div);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdz_q <= SDZ_RST;
			rdz_q <= RDZ_RST;
			scale_q <= SCALE_RST;
			heading_q <= '0;
			prior_q <= '0;
			deg_q <= '0;
			powers_q <= '{default: '0};
			tag_s1 <= OP_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STICK_DZ:    sdz_q <= cfg_data[SDZ_W-1:0];
					CFG_RATE_DZ:     rdz_q <= cfg_data[RDZ_W-1:0];
					CFG_DRIVE_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			tag_s1 <= cmd.op;
			case (tag_s1)
				OP_RATE: begin
					if (rate_mag > RATE_W'(rdz_q))
						heading_q <= hwrap;
					prior_q <= elapsed_q;
				end
				OP_RECIP: deg_q <= deg_next;
				OP_W0:    powers_q[0] <= pwr_sat;
				OP_W1:    powers_q[1] <= pwr_sat;
				OP_W2:    powers_q[2] <= pwr_sat;
				OP_W3:    powers_q[3] <= pwr_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			joy_q <= mode;
			rate_q <= gyro_rate;
			elapsed_q <= elapsed_ms;
			x_q <= (ax < (STICK_W+1)'(sdz_q)) ? '0 : stick_x;
			y_q <= (ay < (STICK_W+1)'(sdz_q)) ? '0 : stick_y;
			t_q <= stick_turn;
			s_q <= sin_now;
			c_q <= cos_now;
		end
		prod_s1 <= prod;
		case (tag_s1)
			OP_CX: acc_q <= prod_s1;
			OP_SX: acc_q <= prod_s1;
			OP_SY: rx_q <= trunc_shift(rx_sum);
			OP_CY: ry_q <= trunc_shift(ry_sum);
			default: ;
		endcase
		if (cmd.out_load) begin
			res_heading_q <= heading_q;
			res_power_q <= powers_q;
		end
	end

	assign sts.joystick = joy_q;
	assign heading_mdeg = res_heading_q;
	assign front_left_power = res_power_q[0];
	assign back_left_power = res_power_q[1];
	assign front_right_power = res_power_q[2];
	assign back_right_power = res_power_q[3];

endmodule

FILE: hdl/fomd_ctrl.sv
// Sequencer of the mecanum drive: steps the shared multiplier through a
// gyro or joystick request and owns the handshakes. Depends on fomd_pkg.
module fomd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  fomd_pkg::sts_t sts,
	output fomd_pkg::cmd_t cmd
);
	import fomd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_G_APPLY,
		S_G_RECIP,
		S_J_SY,
		S_J_SX,
		S_J_CY,
		S_J_GAP,
		S_J_W0,
		S_J_W1,
		S_J_W2,
		S_J_W3,
		S_J_TAIL,
		S_FINISH
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic res_free;

	assign res_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.out_load = (state_q == S_FINISH) && res_free;
		case (state_q)
			S_START:   cmd.op = sts.joystick ? OP_CX : OP_RATE;
			S_G_RECIP: cmd.op = OP_RECIP;
			S_J_SY:    cmd.op = OP_SY;
			S_J_SX:    cmd.op = OP_SX;
			S_J_CY:    cmd.op = OP_CY;
			S_J_W0:    cmd.op = OP_W0;
			S_J_W1:    cmd.op = OP_W1;
			S_J_W2:    cmd.op = OP_W2;
			S_J_W3:    cmd.op = OP_W3;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:    if (in_valid) state_q <= S_START;
				S_START:   state_q <= sts.joystick ? S_J_SY : S_G_APPLY;
				S_G_APPLY: state_q <= S_G_RECIP;
				S_G_RECIP: state_q <= S_FINISH;
				S_J_SY:    state_q <= S_J_SX;
				S_J_SX:    state_q <= S_J_CY;
				S_J_CY:    state_q <= S_J_GAP;
				S_J_GAP:   state_q <= S_J_W0;
				S_J_W0:    state_q <= S_J_W1;
				S_J_W1:    state_q <= S_J_W2;
				S_J_W2:    state_q <= S_J_W3;
				S_J_W3:    state_q <= S_J_TAIL;
				S_J_TAIL:  state_q <= S_FINISH;
				S_FINISH:  if (res_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is pending");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !cmd.out_load))
		else $error("second request taken while one is in work");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_op_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_NONE) |-> !in_ready)
		else $error("multiplier issued while idle");

endmodule

FILE: hdl/field_oriented_mecanum_drive.sv
// Field-oriented mecanum drive with a gyro-integrated heading. A request is
// either a gyro sample (mode 0), which integrates the rate over the interval of
// the previous gyro sample into the millidegree heading, or a joystick sample
// (mode 1), which rotates the stick by the whole-degree heading and mixes it
// with turn into four wheel powers scaled by drive_scale/256 and saturated to
// +/-100. Every request gives one result with the heading and the four powers.
// One request is in work at a time, all products going through a single 21x21
// multiplier with a registered output. A gyro sample takes two products, the
// second turning the heading into whole degrees; a joystick sample takes four
// rotation and four wheel products. The result sits in an output register, so
// the next request is accepted while it waits; the sequencer only stalls if a
// new result is done before the previous one was taken. The user must write
// registers through cfg_we, cfg_index and cfg_data only while no request is in
// work; the block itself does not enforce it.
module field_oriented_mecanum_drive #(
	parameter int TRIG_FRACTION_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fomd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fomd_pkg::CFG_DATA_W-1:0] cfg_data,
	fomd_sample_if.sink sample,
	fomd_result_if.source result
);
	import fomd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fomd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts(sts),
		.cmd(cmd)
	);

	fomd_dp #(
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.mode(sample.mode),
		.gyro_rate(sample.gyro_rate),
		.elapsed_ms(sample.elapsed_ms),
		.stick_x(sample.stick_x),
		.stick_y(sample.stick_y),
		.stick_turn(sample.stick_turn),
		.heading_mdeg(result.heading_mdeg),
		.front_left_power(result.front_left_power),
		.back_left_power(result.back_left_power),
		.front_right_power(result.front_right_power),
		.back_right_power(result.back_right_power)
	);

endmodule
